// ===== rtl/polynomial_evaluator_defines.svh =====
// Assertion macros for the polynomial evaluator.
// Included by the top level; define NO_ASSERTIONS to compile them out.
`ifndef POLYNOMIAL_EVALUATOR_DEFINES_SVH
`define POLYNOMIAL_EVALUATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define POLY_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define POLY_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define POLY_ASSERT_IMP(name, clk, rst_n, ante, cons)

`define POLY_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/poly_pkg.sv =====
// Shared types and constants for the polynomial evaluator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package poly_pkg;

    localparam int WORD_W    = 32;
    localparam int NUM_COEFS = 8;
    localparam int IDX_W     = $clog2(NUM_COEFS);

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]  coef_idx_t;

    // beat moving between Horner steps: partial sum and evaluation point
    typedef struct packed {
        word_t acc;
        word_t x;
    } beat_t;

endpackage

`default_nettype wire

// ===== rtl/poly_coefs.sv =====
// Coefficient register file, written through the configuration port.
// Depends on poly_pkg.
`timescale 1ns / 1ps
`default_nettype none

module poly_coefs
    import poly_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  coef_idx_t                        cfg_index,
    input  word_t                            cfg_data,
    output logic [NUM_COEFS-1:0][WORD_W-1:0] coef
);

    logic [NUM_COEFS-1:0][WORD_W-1:0] coef_reg;
    logic [NUM_COEFS-1:0][WORD_W-1:0] coef_next;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_we)
        begin
            coef_next[cfg_index] = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

`default_nettype wire

// ===== rtl/poly_step.sv =====
// One Horner step, acc * x + coef, as a multiply stage and an add stage.
// Depends on poly_pkg. Low 32 bits only; signed and unsigned agree.
`timescale 1ns / 1ps
`default_nettype none

module poly_step
    import poly_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  beat_t in_beat,
    input  word_t coef,
    output logic  out_valid,
    input  logic  out_stall,
    output beat_t out_beat
);

    logic  mul_valid_reg;
    logic  mul_valid_next;
    word_t prod_reg;
    word_t prod_next;
    word_t mul_x_reg;
    logic  add_valid_reg;
    logic  add_valid_next;
    beat_t add_beat_reg;
    beat_t add_beat_next;
    logic  add_en;
    logic  mul_en;

    // a stage loads when empty or when its content moves on
    assign add_en   = !add_valid_reg || !out_stall;
    assign mul_en   = !mul_valid_reg || add_en;
    assign in_stall = !mul_en;

    always_comb
    begin
        mul_valid_next = mul_valid_reg;
        prod_next      = prod_reg;
        if (mul_en)
        begin
            mul_valid_next = in_valid;
            prod_next      = in_beat.acc * in_beat.x;
        end
    end

    always_comb
    begin
        add_valid_next = add_valid_reg;
        add_beat_next  = add_beat_reg;
        if (add_en)
        begin
            add_valid_next    = mul_valid_reg;
            add_beat_next.acc = prod_reg + coef;
            add_beat_next.x   = mul_x_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            add_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= mul_valid_next;
            add_valid_reg <= add_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        add_beat_reg <= add_beat_next;
        if (mul_en)
        begin
            mul_x_reg <= in_beat.x;
        end
    end

    assign out_valid = add_valid_reg;
    assign out_beat  = add_beat_reg;

endmodule

`default_nettype wire

// ===== rtl/polynomial_evaluator.sv =====
// Polynomial evaluator: result = sum of coef_k * point^k for k = 0..7, wrapped to 32 bits.
// Depends on poly_pkg, poly_coefs, poly_step and polynomial_evaluator_defines.svh.
//
// Accepts one point per cycle while in_stall is low and returns one result per point, in
// order. The pipeline is seven Horner steps, each a registered 32x32 multiply followed by
// a registered add. Each stage loads when it is empty or its beat moves on, so bubbles
// close up under a stall and new points keep entering while a result waits at the output
// until the pipeline is full. Coefficients reset to zero. The user must write them only
// while the pipeline is empty; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

`include "polynomial_evaluator_defines.svh"

module polynomial_evaluator
    import poly_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [WORD_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [WORD_W-1:0] point,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [WORD_W-1:0] result
);

    localparam int NUM_STEPS = NUM_COEFS - 1;

    logic [NUM_COEFS-1:0][WORD_W-1:0] coef;
    logic                             valid [NUM_STEPS+1];
    logic                             stall [NUM_STEPS+1];
    beat_t                            beat  [NUM_STEPS+1];

    poly_coefs u_coefs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    // highest coefficient seeds the accumulator
    assign valid[0]    = in_valid;
    assign in_stall    = stall[0];
    assign beat[0].acc = coef[NUM_COEFS-1];
    assign beat[0].x   = unsigned'(point);

    for (genvar i = 0; i < NUM_STEPS; i++)
    begin : g_step
        poly_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid[i]),
            .in_stall  (stall[i]),
            .in_beat   (beat[i]),
            .coef      (coef[NUM_STEPS-1-i]),
            .out_valid (valid[i+1]),
            .out_stall (stall[i+1]),
            .out_beat  (beat[i+1])
        );
    end

    assign out_valid          = valid[NUM_STEPS];
    assign stall[NUM_STEPS]   = out_stall;
    assign result             = signed'(beat[NUM_STEPS].acc);

    // input back-pressure only arises from a held result at the output
    `POLY_ASSERT_IMP(a_stall_from_output, clk, rst_n, in_stall, out_valid && out_stall)
    // no input stall while the output drains
    `POLY_ASSERT_IMP(a_no_stall_when_free, clk, rst_n, !out_stall, !in_stall)
    // a configuration write lands in the addressed coefficient
    `POLY_ASSERT_NEXT(a_cfg_write, clk, rst_n, cfg_we, coef[$past(cfg_index)] == $past(cfg_data))

endmodule

`default_nettype wire

// ===== verif/polynomial_evaluator_checker.sv =====
// Checker for the polynomial evaluator: mirrors coefficient writes, predicts
// each result by Horner evaluation and compares results in order.
// Depends on poly_pkg.
`timescale 1ns / 1ps

module polynomial_evaluator_checker
    import poly_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [WORD_W-1:0]        cfg_data,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic signed [WORD_W-1:0] point,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [WORD_W-1:0] result,
    output int                       mismatches,
    output int                       outstanding,
    output int                       checked
);

    word_t coefs [NUM_COEFS];
    word_t pending_values [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        checked     = 0;
    end

    // all arithmetic at 32 bits, so every step wraps
    function automatic word_t poly_at(input word_t x);
        word_t acc;
        int    k;
        acc = '0;
        for (k = NUM_COEFS - 1; k >= 0; k--)
            acc = acc * x + coefs[k];
        return acc;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        word_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEFS; i++)
                coefs[i] = '0;
            pending_values.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
                coefs[cfg_index] = cfg_data;
            if (in_valid && !in_stall)
                pending_values = {pending_values, poly_at(word_t'(point))};
            if (out_valid && !out_stall)
            begin
                checked++;
                if (pending_values.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result beat %h with nothing expected", $realtime, result);
                    mismatches++;
                end
                else
                begin
                    want = pending_values.pop_front();
                    if (word_t'(result) !== want)
                    begin
                        if (mismatches < 10)
                            $display("%0t: result mismatch, expected %h, got %h",
                                     $realtime, want, result);
                        mismatches++;
                    end
                end
            end
            outstanding = pending_values.size();
        end
    end

endmodule

// ===== verif/polynomial_evaluator_tb.sv =====
// Top of the polynomial evaluator testbench: clock, reset, coefficient
// writes, point stimulus with bursts and gaps, output stall patterns.
// Depends on poly_pkg, polynomial_evaluator and polynomial_evaluator_checker.
`timescale 1ns / 1ps

module polynomial_evaluator_tb;
    import poly_pkg::*;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
    typedef enum int {COEF_RANDOM, COEF_MAX, COEF_MIN, COEF_ALT, COEF_SPARSE, COEF_SMALL,
                      COEF_ONES} coef_kind_t;

    localparam int LONG_HOLD    = 150;
    localparam int PHASE_POINTS = 170;
    localparam int DRAIN_CYCLES = 20;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [IDX_W-1:0]         cfg_index = '0;
    logic [WORD_W-1:0]        cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic signed [WORD_W-1:0] point     = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [WORD_W-1:0] result;

    int mismatches;
    int outstanding;
    int checked;
    int hold_ticket = 0;
    int points_sent = 0;
    int coef_sets   = 0;

    word_t coef_set [NUM_COEFS];

    polynomial_evaluator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .point     (point),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    polynomial_evaluator_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .point       (point),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    initial
    begin
        #1000000;
        $display("polynomial_evaluator regression: fail");
        $finish;
    end

    // output side: random stall patterns per segment, long hold on request
    always @(posedge clk)
    begin
        static stall_mode_t mode = STALL_NONE;
        static int seg_left = 0;
        static int hold_left = 0;
        static int hold_served = 0;
        static int phase_cnt = 0;
        if (hold_served != hold_ticket)
        begin
            hold_served = hold_ticket;
            hold_left   = LONG_HOLD;
        end
        if (seg_left == 0)
        begin
            mode     = stall_mode_t'($urandom_range(0, 3));
            seg_left = $urandom_range(16, 96);
        end
        seg_left--;
        phase_cnt++;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            case (mode)
                STALL_NONE:     out_stall <= 1'b0;
                STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
                default:        out_stall <= (phase_cnt % 3 == 0);
            endcase
        end
    end

    // holds valid and payload until the beat is taken
    task automatic send_point(input word_t value);
        logic taken;
        in_valid <= 1'b1;
        point    <= value;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        points_sent++;
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    task automatic load_coefs();
        for (int i = 0; i < NUM_COEFS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= coef_idx_t'(i);
            cfg_data  <= coef_set[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        coef_sets++;
    endtask

    task automatic fill_coefs(input coef_kind_t kind);
        for (int i = 0; i < NUM_COEFS; i++)
        begin
            case (kind)
                COEF_MAX:    coef_set[i] = 32'h7FFF_FFFF;
                COEF_MIN:    coef_set[i] = 32'h8000_0000;
                COEF_ALT:    coef_set[i] = i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                COEF_SPARSE: coef_set[i] = ($urandom_range(0, 2) == 0) ? $urandom : '0;
                COEF_SMALL:  coef_set[i] = word_t'($urandom_range(0, 15)) - 32'd8;
                COEF_ONES:   coef_set[i] = 32'd1;
                default:     coef_set[i] = $urandom;
            endcase
        end
    endtask

    function automatic word_t corner_point(input int n);
        case (n)
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0002;
            4:       return 32'hFFFF_FFFE;
            5:       return 32'h7FFF_FFFF;
            6:       return 32'h8000_0000;
            7:       return 32'h5555_5555;
            8:       return 32'hAAAA_AAAA;
            9:       return 32'h0001_0000;
            default: return 32'h0000_0100;
        endcase
    endfunction

    function automatic word_t pick_point();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return $urandom;
        else if (sel < 8)
            return word_t'($urandom_range(0, 31)) - 32'd16;
        else if (sel == 8)
            return corner_point($urandom_range(0, 10));
        else
            return $urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 31))
                                        : -(32'd1 << $urandom_range(0, 31));
    endfunction

    task automatic run_points(input int count, input logic with_gaps);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst && sent < count; j++)
            begin
                send_point(pick_point());
                sent++;
            end
            gap = (!with_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        coef_kind_t kinds [8];
        kinds[0] = COEF_RANDOM;
        kinds[1] = COEF_MAX;
        kinds[2] = COEF_SPARSE;
        kinds[3] = COEF_MIN;
        kinds[4] = COEF_SMALL;
        kinds[5] = COEF_RANDOM;
        kinds[6] = COEF_ALT;
        kinds[7] = COEF_RANDOM;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // coefficients still at reset: everything evaluates to zero
        send_point(corner_point(5));
        send_point(corner_point(6));
        in_valid <= 1'b0;
        drain();

        fill_coefs(COEF_ONES);
        load_coefs();
        for (int n = 0; n < 11; n++)
            send_point(corner_point(n));
        in_valid <= 1'b0;
        drain();

        fill_coefs(COEF_ALT);
        load_coefs();
        for (int n = 0; n < 11; n++)
            send_point(corner_point(n));
        in_valid <= 1'b0;
        drain();

        for (int p = 0; p < 8; p++)
        begin
            fill_coefs(kinds[p]);
            load_coefs();
            if (p == 2 || p == 5)
                hold_ticket <= hold_ticket + 1;
            if (p == 3)
            begin
                run_points(PHASE_POINTS / 2, 1'b1);
                drain();
                run_points(PHASE_POINTS - PHASE_POINTS / 2, 1'b1);
            end
            else
                run_points(PHASE_POINTS, p != 4);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        $display("covered %0d points over %0d coefficient sets plus reset values, %0d results checked",
                 points_sent, coef_sets, checked);
        if (mismatches == 0 && outstanding == 0)
            $display("polynomial_evaluator regression: pass");
        else
            $display("polynomial_evaluator regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/poly_pkg.sv
rtl/poly_coefs.sv
rtl/poly_step.sv
rtl/polynomial_evaluator.sv
verif/polynomial_evaluator_checker.sv
verif/polynomial_evaluator_tb.sv
